// File: hdl/dps_pkg.sv
// Shared types and field widths for the deadline profit scheduler.
package dps_pkg;

    localparam int DEADLINE_W = 12;
    localparam int DURATION_W = 12;
    localparam int PROFIT_W   = 16;
    localparam int VALUE_W    = 32;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SWEEP  = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

endpackage

// File: hdl/deadline_profit_schedule_dp.sv
// Deadline profit scheduler: one best profit row updated in place per job.
//
// Jobs arrive on the input channel (i_valid, o_stall) sorted by deadline.
// Each accepted item sweeps the row from column MAX_TIME down to column 0,
// one read-modify-write per cycle through one adder and comparator, with
// a second memory read port supplying the source column. After an item is
// accepted, o_stall stays high through the sweep, drain and finish states,
// so the block takes no new item until it is through with the last one. A
// job flagged last leaves one result on the output channel (o_valid, i_stall)
// once its sweep is done: the row value at the job's deadline, clipped to
// MAX_TIME, and the sticky order error of the set. The result register holds
// its value while i_stall is high; the next job can be taken meanwhile, and
// if it is flagged last, its sweep waits at the end while a result is still
// unclaimed.
// Reset is synchronous and clears all control state. The row memory is
// not cleared by reset; the first sweep after reset, like any sweep of a
// job flagged first, treats the stored row as zero and rewrites every
// column, so no clearing pass is needed.
module deadline_profit_schedule_dp #(
    parameter int MAX_TIME = 4095
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_first,
    input  logic                            i_last,
    input  logic [dps_pkg::DEADLINE_W-1:0]  i_deadline,
    input  logic [dps_pkg::DURATION_W-1:0]  i_duration,
    input  logic [dps_pkg::PROFIT_W-1:0]    i_profit,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [dps_pkg::VALUE_W-1:0]     o_best_profit,
    output logic                            o_order_error
);

    localparam int DEPTH = MAX_TIME + 1;
    localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW    = (AW > dps_pkg::DEADLINE_W) ? AW : dps_pkg::DEADLINE_W;
    localparam int VW    = dps_pkg::VALUE_W;

    localparam logic [AW-1:0] LAST_COL = AW'(MAX_TIME);
    localparam logic [CW-1:0] MAX_C    = CW'(MAX_TIME);

    logic [VW-1:0] r_row_mem [DEPTH];

    dps_pkg::t_state r_state, n_state;

    logic                          r_clean;
    logic                          r_zero;
    logic                          r_last;
    logic [dps_pkg::DEADLINE_W-1:0] r_deadline;
    logic [dps_pkg::DURATION_W-1:0] r_duration;
    logic [dps_pkg::PROFIT_W-1:0]   r_profit;
    logic [dps_pkg::DEADLINE_W-1:0] r_prev_deadline;
    logic                          r_fault;
    logic [AW-1:0]                 r_col;

    logic                          r_w_valid;
    logic [AW-1:0]                 r_w_col;
    logic                          r_w_upd;
    logic                          r_w_pick;
    logic [VW-1:0]                 r_rd_old;
    logic [VW-1:0]                 r_rd_src;
    logic [VW-1:0]                 r_pick_val;

    logic                          r_out_valid;
    logic [VW-1:0]                 r_out_value;
    logic                          r_out_error;

    logic                          in_take;
    logic [CW-1:0]                 col_ext;
    logic [CW-1:0]                 dl_ext;
    logic [CW-1:0]                 dur_ext;
    logic [CW-1:0]                 lim;
    logic [CW-1:0]                 pick;
    logic [CW-1:0]                 src_ext;
    logic                          upd;
    logic [AW-1:0]                 src_addr;
    logic [VW:0]                   sum;
    logic [VW-1:0]                 cand;
    logic [VW-1:0]                 old_eff;
    logic [VW-1:0]                 new_val;
    logic                          out_free;

    assign in_take  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != dps_pkg::S_IDLE);

    always_comb begin
        col_ext  = CW'(r_col);
        dl_ext   = CW'(r_deadline);
        dur_ext  = CW'(r_duration);
        lim      = (col_ext < dl_ext) ? col_ext : dl_ext;
        pick     = (dl_ext < MAX_C) ? dl_ext : MAX_C;
        upd      = (r_col != '0) && (dur_ext <= lim);
        src_ext  = upd ? (lim - dur_ext) : '0;
        src_addr = src_ext[AW-1:0];
    end

    always_comb begin
        sum     = (r_zero ? '0 : {1'b0, r_rd_src}) + (VW+1)'(r_profit);
        cand    = sum[VW] ? '1 : sum[VW-1:0];
        old_eff = r_zero ? '0 : r_rd_old;
        new_val = (r_w_upd && (cand > old_eff)) ? cand : old_eff;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == dps_pkg::S_SWEEP) begin
            r_rd_old <= r_row_mem[r_col];
            r_rd_src <= r_row_mem[src_addr];
        end
        if (r_w_valid) begin
            r_row_mem[r_w_col] <= new_val;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dps_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = dps_pkg::S_SWEEP;
                end
            end
            dps_pkg::S_SWEEP: begin
                if (r_col == '0) begin
                    n_state = dps_pkg::S_DRAIN;
                end
            end
            dps_pkg::S_DRAIN: begin
                n_state = dps_pkg::S_FINISH;
            end
            dps_pkg::S_FINISH: begin
                if (!r_last || out_free) begin
                    n_state = dps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dps_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= dps_pkg::S_IDLE;
            r_clean         <= 1'b1;
            r_zero          <= 1'b0;
            r_prev_deadline <= '0;
            r_fault         <= 1'b0;
            r_w_valid       <= 1'b0;
            r_out_valid     <= 1'b0;
            r_last          <= 1'b0;
            r_col           <= '0;
        end else begin
            r_state   <= n_state;
            r_w_valid <= (r_state == dps_pkg::S_SWEEP);

            if (in_take) begin
                r_zero          <= r_clean || i_first;
                r_clean         <= 1'b0;
                r_last          <= i_last;
                r_prev_deadline <= i_deadline;
                r_col           <= LAST_COL;
                if (i_first) begin
                    r_fault <= 1'b0;
                end else if (i_deadline < r_prev_deadline) begin
                    r_fault <= 1'b1;
                end
            end else if (r_state == dps_pkg::S_SWEEP && r_col != '0) begin
                r_col <= r_col - AW'(1);
            end

            if (r_state == dps_pkg::S_FINISH && r_last && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_deadline <= i_deadline;
            r_duration <= i_duration;
            r_profit   <= i_profit;
        end
        if (r_state == dps_pkg::S_SWEEP) begin
            r_w_col  <= r_col;
            r_w_upd  <= upd;
            r_w_pick <= (col_ext == pick);
        end
        if (r_w_valid && r_w_pick) begin
            r_pick_val <= new_val;
        end
        if (r_state == dps_pkg::S_FINISH && r_last && out_free) begin
            r_out_value <= r_pick_val;
            r_out_error <= r_fault;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_best_profit = r_out_value;
    assign o_order_error = r_out_error;

endmodule

// File: tb/schedule_scoreboard_pkg.sv
// Scoreboard class that predicts and checks the scheduler's best profit results.
package schedule_scoreboard_pkg;

    typedef struct packed {
        logic [dps_pkg::VALUE_W-1:0] best_profit;
        logic                        order_error;
    } t_schedule_result;

    class schedule_scoreboard;
        int unsigned                  row_top;
        bit [dps_pkg::VALUE_W-1:0]    best_row[];
        bit [dps_pkg::DEADLINE_W-1:0] prior_deadline;
        bit                           order_fault;
        t_schedule_result             pending_results[$];
        int unsigned                  failures;
        int unsigned                  results_seen;

        function new(int unsigned row_top_i);
            row_top = row_top_i;
            best_row = new[row_top_i + 1];
            foreach (best_row[i]) best_row[i] = '0;
            prior_deadline = '0;
            order_fault = 1'b0;
            failures = 0;
            results_seen = 0;
        endfunction

        // Sweeps the row from the top column down, in place, for one accepted job.
        function void note_job(bit first, bit last, bit [dps_pkg::DEADLINE_W-1:0] deadline,
                               bit [dps_pkg::DURATION_W-1:0] duration,
                               bit [dps_pkg::PROFIT_W-1:0] profit);
            int unsigned               col;
            int unsigned               lim;
            int unsigned               dl;
            int unsigned               dur;
            bit [dps_pkg::VALUE_W:0]   sum;
            bit [dps_pkg::VALUE_W-1:0] cand;
            t_schedule_result          res;
            dl = 32'(deadline);
            dur = 32'(duration);
            if (first) begin
                foreach (best_row[i]) best_row[i] = '0;
                order_fault = 1'b0;
            end else if (deadline < prior_deadline) begin
                order_fault = 1'b1;
            end
            prior_deadline = deadline;
            for (col = row_top; col >= 1; col--) begin
                lim = (col < dl) ? col : dl;
                if (dur <= lim) begin
                    sum = {1'b0, best_row[lim - dur]} + (dps_pkg::VALUE_W + 1)'(profit);
                    cand = sum[dps_pkg::VALUE_W] ? '1 : sum[dps_pkg::VALUE_W-1:0];
                    if (cand > best_row[col]) best_row[col] = cand;
                end
            end
            if (last) begin
                res.best_profit = best_row[(dl < row_top) ? dl : row_top];
                res.order_error = order_fault;
                pending_results.push_back(res);
            end
        endfunction

        function void check_result(bit [dps_pkg::VALUE_W-1:0] best_profit, bit order_error);
            t_schedule_result want;
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: best_profit %0d order_error %0d",
                       best_profit, order_error);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            if (want.best_profit != best_profit) begin
                $error("best_profit: expected %0d, got %0d", want.best_profit, best_profit);
                failures++;
            end
            if (want.order_error != order_error) begin
                $error("order_error: expected %0d, got %0d", want.order_error, order_error);
                failures++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

endpackage

// File: tb/tb_top.sv
// Top level testbench for the deadline profit scheduler.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [dps_pkg::DEADLINE_W-1:0] t_deadline;
    typedef logic [dps_pkg::DURATION_W-1:0] t_duration;
    typedef logic [dps_pkg::PROFIT_W-1:0]   t_profit;
    typedef logic [dps_pkg::VALUE_W-1:0]    t_value;

    localparam int unsigned ROW_TOP         = 4095;
    localparam int unsigned RANDOM_JOBS     = 120;
    localparam int unsigned HOLD_OFF_CYCLES = 20000;
    localparam int unsigned TIMEOUT_NS      = 100_000_000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    logic      i_first = 1'b0;
    logic      i_last = 1'b0;
    t_deadline i_deadline = '0;
    t_duration i_duration = '0;
    t_profit   i_profit = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_value    o_best_profit;
    logic      o_order_error;

    schedule_scoreboard_pkg::schedule_scoreboard board;
    int unsigned        jobs_sent = 0;
    bit                 hold_off_done = 1'b0;

    deadline_profit_schedule_dp #(
        .MAX_TIME(ROW_TOP)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_first(i_first),
        .i_last(i_last),
        .i_deadline(i_deadline),
        .i_duration(i_duration),
        .i_profit(i_profit),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_best_profit(o_best_profit),
        .o_order_error(o_order_error)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            board.note_job(i_first, i_last, i_deadline, i_duration, i_profit);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_result(o_best_profit, o_order_error);
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 40);
        return $urandom_range(200, 5000);
    endfunction

    // Offers one item after a random gap and returns at the edge that accepts it.
    task automatic send_job(bit first, bit last, t_deadline deadline,
                            t_duration duration, t_profit profit);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_first <= first;
        i_last <= last;
        i_deadline <= deadline;
        i_duration <= duration;
        i_profit <= profit;
        do @(posedge i_clk); while (o_stall);
        jobs_sent++;
    endtask

    task automatic send_sorted_set();
        int unsigned span;
        int unsigned count;
        int unsigned deadline;
        int unsigned duration;
        span = $urandom_range(0, 1) ? 4095 : 63;
        count = $urandom_range(1, 5);
        deadline = $urandom_range(0, span);
        for (int unsigned k = 0; k < count; k++) begin
            deadline = deadline + $urandom_range(0, span / 2);
            if (deadline > 4095) deadline = 4095;
            if ($urandom_range(0, 7) == 0) duration = $urandom_range(0, 4095);
            else duration = $urandom_range(0, deadline);
            send_job(k == 0, k == count - 1, t_deadline'(deadline), t_duration'(duration),
                     t_profit'($urandom()));
        end
    endtask

    task automatic send_unsorted_set();
        int unsigned count;
        count = $urandom_range(2, 5);
        for (int unsigned k = 0; k < count; k++) begin
            send_job((k == 0) && ($urandom_range(0, 3) != 0), k == count - 1,
                     t_deadline'($urandom()), t_duration'($urandom_range(0, 300)),
                     t_profit'($urandom()));
        end
    endtask

    initial begin
        int unsigned random_start;
        int unsigned kind;
        board = new(ROW_TOP);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_job(1'b1, 1'b1, 12'd0, 12'd0, 16'hFFFF);
        send_job(1'b1, 1'b1, 12'hFFF, 12'hFFF, 16'hFFFF);
        send_job(1'b1, 1'b1, 12'd10, 12'd11, 16'd100);
        send_job(1'b1, 1'b0, 12'd4, 12'd2, 16'd50);
        send_job(1'b0, 1'b0, 12'd4, 12'd2, 16'd60);
        send_job(1'b0, 1'b1, 12'd5, 12'd2, 16'd70);
        send_job(1'b1, 1'b0, 12'd100, 12'd10, 16'd5);
        send_job(1'b0, 1'b0, 12'd50, 12'd5, 16'd7);
        send_job(1'b0, 1'b1, 12'd200, 12'd100, 16'd9);
        send_job(1'b1, 1'b1, 12'd300, 12'd0, 16'd0);
        send_job(1'b0, 1'b1, 12'hFFF, 12'd1, 16'hFFFF);
        send_job(1'b1, 1'b1, 12'hFFF, 12'd0, 16'hFFFF);
        send_job(1'b1, 1'b1, 12'd1, 12'd1, 16'd0);
        send_job(1'b1, 1'b0, 12'd7, 12'd0, 16'd1000);
        send_job(1'b0, 1'b1, 12'd7, 12'd0, 16'd2000);
        send_job(1'b0, 1'b0, 12'd3, 12'd3, 16'd40000);
        send_job(1'b0, 1'b1, 12'd2048, 12'd2045, 16'd32768);
        send_job(1'b1, 1'b1, 12'd2, 12'd1, 16'hAAAA);
        send_job(1'b1, 1'b1, 12'hAAA, 12'h555, 16'h5555);
        send_job(1'b1, 1'b1, 12'h555, 12'hAAA, 16'h0001);

        random_start = jobs_sent;
        while (jobs_sent - random_start < RANDOM_JOBS) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                send_sorted_set();
            end else if (kind < 90) begin
                send_unsorted_set();
            end else begin
                send_job(1'($urandom()), 1'($urandom()), t_deadline'($urandom()),
                         t_duration'($urandom()), t_profit'($urandom()));
            end
        end
        send_job(1'b0, 1'b1, t_deadline'($urandom()), t_duration'($urandom_range(0, 20)),
                 t_profit'($urandom()));
        i_valid <= 1'b0;

        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (ROW_TOP + 16) @(posedge i_clk);
        if (board.failures == 0 && board.outstanding() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // The receiver stalls in random stretches, and once holds off long enough
    // for the block to fill up and stall its input.
    initial begin
        int unsigned ready_len;
        int unsigned stall_len;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_off_done && board.results_seen > 0) begin
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_done = 1'b1;
            end
            ready_len = pick_gap() + 1;
            stall_len = pick_gap();
            i_stall <= 1'b0;
            repeat (ready_len) @(posedge i_clk);
            if (stall_len > 0) begin
                i_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hdl/dps_pkg.sv
hdl/deadline_profit_schedule_dp.sv
tb/schedule_scoreboard_pkg.sv
tb/tb_top.sv
